// ===== design/lrg_pkg.sv =====
`default_nettype none

package lrg_pkg;

    localparam int GAIN_FRAC_BITS = 12;
    localparam int MAX_CHANNELS   = 2;

    localparam logic [15:0] RATE_MIN = 16'd8000;
    localparam logic [15:0] RATE_MAX = 16'd48000;

    localparam logic [15:0] RESET_INPUT_RATE  = 16'd16000;
    localparam logic [15:0] RESET_OUTPUT_RATE = 16'd16000;
    localparam logic [1:0]  RESET_CHANNELS    = 2'd1;
    localparam logic [15:0] RESET_GAIN        = 16'd4096;

    // results per input frame
    localparam logic [3:0] MAX_RESULTS = 4'd12;
    // frames passed per output step, worst case over the rate range
    localparam int MAX_SKIP = (int'(RATE_MIN) + int'(RATE_MAX) - 1) / int'(RATE_MIN);

    localparam logic signed [15:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAT_MIN = 16'sh8000;

    localparam logic [1:0] REG_INPUT_RATE  = 2'd0;
    localparam logic [1:0] REG_OUTPUT_RATE = 2'd1;
    localparam logic [1:0] REG_CHANNELS    = 2'd2;
    localparam logic [1:0] REG_GAIN        = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_LOOP1,
        ST_HOLD,
        ST_LOOP2,
        ST_MUL0,
        ST_MUL1,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_FIN,
        ST_GAIN,
        ST_ADV_ADD,
        ST_ADV_SUB,
        ST_PUSH
    } state_t;

    function automatic logic [15:0] clamp_rate(input logic [15:0] r);
        logic [15:0] c;
        c = r;
        if (r < RATE_MIN) begin
            c = RATE_MIN;
        end else if (r > RATE_MAX) begin
            c = RATE_MAX;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/linear_resampler_with_gain_top.sv =====
`default_nettype none

// Linear-interpolation sample-rate converter with Q4.12 gain. One PCM frame
// (mono or stereo) is taken per input transfer and yields zero to twelve
// result transfers; m_last_of_run marks the final one caused by that frame.
// Output positions are tracked exactly as a frame offset plus a remainder
// below the output rate, and each sample is trunc((s0*(out-r)+s1*r)/out),
// scaled by the gain, truncated toward zero and saturated to 16 bits. A frame
// with s_block_end set flushes the repeated last frame and restarts the
// position. The multiplies share one 17x17 multiplier and the output-rate
// comparisons one 18-bit subtractor under a sequencer; s_ready is high only
// while idle. Each frame first reduces the position remainder; each result
// then takes, per channel, two multiplies, a 16-step restoring divide by the
// output rate, sign fix and gain when interpolating, or only the gain when
// the position falls exactly on a frame or the last frame is repeated, then
// advances the position by at most 6 output-rate subtractions and waits on m_ready. Rates are
// clamped to 8000..48000 Hz; write configuration only while idle.

module linear_resampler_with_gain_top
    import lrg_pkg::*;
(
    input  wire                aclk,
    input  wire                aresetn,

    input  wire                cfg_we,
    input  wire  [1:0]         cfg_index,
    input  wire  [15:0]        cfg_data,

    input  wire                s_valid,
    output logic               s_ready,
    input  wire  signed [15:0] s_left_sample,
    input  wire  signed [15:0] s_right_sample,
    input  wire                s_block_end,

    output logic               m_valid,
    input  wire                m_ready,
    output logic signed [15:0] m_left_out,
    output logic signed [15:0] m_right_out,
    output logic               m_last_of_run
);

    state_t state_reg, state_next;

    logic [15:0] in_rate_reg, dst_rate_reg, gain_reg;
    logic [1:0]  chan_reg;

    logic signed [15:0] cur_left_reg, cur_left_next;
    logic signed [15:0] cur_right_reg, cur_right_next;
    logic               end_reg, end_next;
    logic signed [15:0] held_left_reg, held_left_next;
    logic signed [15:0] held_right_reg, held_right_next;
    logic               have_held_reg, have_held_next;
    logic [16:0]        rem_reg, rem_next;
    logic [3:0]         skip_reg, skip_next;
    logic [3:0]         n_reg, n_next;
    logic               ch_reg, ch_next;
    logic               second_reg, second_next;
    logic signed [32:0] acc_reg, acc_next;
    logic [15:0]        rdiv_reg, rdiv_next;
    logic [15:0]        dvd_reg, dvd_next;
    logic               neg_reg, neg_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic signed [15:0] val_reg, val_next;
    logic signed [15:0] res_left_reg, res_left_next;
    logic signed [15:0] res_right_reg, res_right_next;
    logic               m_valid_reg, m_valid_next;
    logic signed [15:0] m_left_reg, m_left_next;
    logic signed [15:0] m_right_reg, m_right_next;
    logic               m_last_reg, m_last_next;

    logic [15:0]        in_r, out_r;
    logic               stereo;
    logic               accept, slot_free, emit_cond, fast_path, more;
    logic [3:0]         n_inc;

    logic [17:0]        sub_a, sub_b, sub_diff;
    logic               sub_ge;

    logic signed [16:0] mul_a;
    logic [15:0]        mul_b;
    logic signed [33:0] mul_p;
    logic signed [15:0] s0, s1;

    logic [32:0]        acc_mag;
    logic [16:0]        quot_signed;
    logic signed [33:0] gain_adj, gain_sh;
    logic signed [15:0] gain_sat;

    localparam logic signed [33:0] GAIN_ROUND = 34'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

    assign in_r   = clamp_rate(in_rate_reg);
    assign out_r  = clamp_rate(dst_rate_reg);
    assign stereo = (MAX_CHANNELS >= 2) && chan_reg[1];

    assign s_ready       = (state_reg == ST_IDLE);
    assign accept        = s_valid && s_ready;
    assign slot_free     = !m_valid_reg || m_ready;
    assign emit_cond     = (skip_reg == 4'd0) && (n_reg < MAX_RESULTS);
    assign fast_path     = (rem_reg == 17'd0) || second_reg;
    assign n_inc         = n_reg + 4'd1;
    assign more          = (n_inc < MAX_RESULTS) &&
                           ((skip_reg == 4'd0) ||
                            (!second_reg && end_reg && (skip_reg == 4'd1)));

    assign m_valid       = m_valid_reg;
    assign m_left_out    = m_left_reg;
    assign m_right_out   = m_right_reg;
    assign m_last_of_run = m_last_reg;

    // shared subtractor, always against the output rate
    always_comb begin
        case (state_reg)
            ST_MUL0: begin
                sub_a = {2'b00, out_r};
                sub_b = {1'b0, rem_reg};
            end
            ST_DIV: begin
                sub_a = {1'b0, rdiv_reg, dvd_reg[15]};
                sub_b = {2'b00, out_r};
            end
            default: begin
                sub_a = {1'b0, rem_reg};
                sub_b = {2'b00, out_r};
            end
        endcase
        sub_diff = sub_a - sub_b;
        sub_ge   = !sub_diff[17];
    end

    // shared multiplier
    assign s0 = ch_reg ? held_right_reg : held_left_reg;
    assign s1 = ch_reg ? cur_right_reg : cur_left_reg;

    always_comb begin
        case (state_reg)
            ST_MUL0: begin
                mul_a = {s0[15], s0};
                mul_b = sub_diff[15:0];
            end
            ST_MUL1: begin
                mul_a = {s1[15], s1};
                mul_b = rem_reg[15:0];
            end
            default: begin
                mul_a = {val_reg[15], val_reg};
                mul_b = gain_reg;
            end
        endcase
    end

    assign mul_p = mul_a * $signed({1'b0, mul_b});

    assign acc_mag     = acc_reg[32] ? 33'(-acc_reg) : 33'(acc_reg);
    assign quot_signed = neg_reg ? 17'(-{1'b0, dvd_reg}) : {1'b0, dvd_reg};

    // gain: truncate toward zero, then saturate
    assign gain_adj = mul_p + (mul_p[33] ? GAIN_ROUND : 34'sd0);
    assign gain_sh  = gain_adj >>> GAIN_FRAC_BITS;
    assign gain_sat = (gain_sh[33:15] == {19{gain_sh[15]}}) ? gain_sh[15:0] :
                      (gain_sh[33] ? SAT_MIN : SAT_MAX);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                if (sub_ge) begin
                    state_next = ST_MOD;
                end else if (!have_held_reg) begin
                    state_next = ST_HOLD;
                end else begin
                    state_next = ST_LOOP1;
                end
            end
            ST_LOOP1:    state_next = emit_cond ? ST_MUL0 : ST_HOLD;
            ST_HOLD:     state_next = end_reg ? ST_LOOP2 : ST_IDLE;
            ST_LOOP2:    state_next = emit_cond ? ST_MUL0 : ST_IDLE;
            ST_MUL0:     state_next = fast_path ? ST_GAIN : ST_MUL1;
            ST_MUL1:     state_next = ST_DIV_INIT;
            ST_DIV_INIT: state_next = ST_DIV;
            ST_DIV: begin
                if (cnt_reg == 4'd15) begin
                    state_next = ST_DIV_FIN;
                end
            end
            ST_DIV_FIN:  state_next = ST_GAIN;
            ST_GAIN:     state_next = (!ch_reg && stereo) ? ST_MUL0 : ST_ADV_ADD;
            ST_ADV_ADD:  state_next = ST_ADV_SUB;
            ST_ADV_SUB: begin
                if (!sub_ge) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (slot_free) begin
                    state_next = second_reg ? ST_LOOP2 : ST_LOOP1;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cur_left_next   = cur_left_reg;
        cur_right_next  = cur_right_reg;
        end_next        = end_reg;
        held_left_next  = held_left_reg;
        held_right_next = held_right_reg;
        have_held_next  = have_held_reg;
        rem_next        = rem_reg;
        skip_next       = skip_reg;
        n_next          = n_reg;
        ch_next         = ch_reg;
        second_next     = second_reg;
        acc_next        = acc_reg;
        rdiv_next       = rdiv_reg;
        dvd_next        = dvd_reg;
        neg_next        = neg_reg;
        cnt_next        = cnt_reg;
        val_next        = val_reg;
        res_left_next   = res_left_reg;
        res_right_next  = res_right_reg;
        m_left_next     = m_left_reg;
        m_right_next    = m_right_reg;
        m_last_next     = m_last_reg;
        m_valid_next    = m_ready ? 1'b0 : m_valid_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cur_left_next  = s_left_sample;
                    cur_right_next = stereo ? s_right_sample : 16'sd0;
                    end_next       = s_block_end;
                    n_next         = 4'd0;
                    second_next    = 1'b0;
                end
            end
            ST_MOD: begin
                if (sub_ge) begin
                    rem_next = sub_diff[16:0];
                end else if (!have_held_reg) begin
                    have_held_next = 1'b1;
                    skip_next      = 4'd0;
                end
            end
            ST_LOOP1: begin
                if (emit_cond) begin
                    ch_next = 1'b0;
                end else if (skip_reg != 4'd0) begin
                    skip_next = skip_reg - 4'd1;
                end
            end
            ST_HOLD: begin
                held_left_next  = cur_left_reg;
                held_right_next = cur_right_reg;
                second_next     = end_reg;
            end
            ST_LOOP2: begin
                if (emit_cond) begin
                    ch_next = 1'b0;
                end else begin
                    have_held_next = 1'b0;
                    rem_next       = 17'd0;
                    skip_next      = 4'd0;
                end
            end
            ST_MUL0: begin
                if (fast_path) begin
                    val_next = s0;
                end else begin
                    acc_next = mul_p[32:0];
                end
            end
            ST_MUL1: begin
                acc_next = acc_reg + mul_p[32:0];
            end
            ST_DIV_INIT: begin
                neg_next  = acc_reg[32];
                rdiv_next = acc_mag[31:16];
                dvd_next  = acc_mag[15:0];
                cnt_next  = 4'd0;
            end
            ST_DIV: begin
                rdiv_next = sub_ge ? sub_diff[15:0] : {rdiv_reg[14:0], dvd_reg[15]};
                dvd_next  = {dvd_reg[14:0], sub_ge};
                cnt_next  = cnt_reg + 4'd1;
            end
            ST_DIV_FIN: begin
                val_next = quot_signed[15:0];
            end
            ST_GAIN: begin
                if (!ch_reg) begin
                    res_left_next = gain_sat;
                end else begin
                    res_right_next = gain_sat;
                end
                if (!ch_reg && stereo) begin
                    ch_next = 1'b1;
                end
            end
            ST_ADV_ADD: begin
                rem_next = rem_reg + {1'b0, in_r};
            end
            ST_ADV_SUB: begin
                if (sub_ge) begin
                    rem_next  = sub_diff[16:0];
                    skip_next = skip_reg + 4'd1;
                end
            end
            ST_PUSH: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_left_next  = res_left_reg;
                    m_right_next = stereo ? res_right_reg : 16'sd0;
                    m_last_next  = !more;
                    n_next       = n_inc;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_rate_reg  <= RESET_INPUT_RATE;
            dst_rate_reg <= RESET_OUTPUT_RATE;
            chan_reg     <= RESET_CHANNELS;
            gain_reg     <= RESET_GAIN;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_INPUT_RATE:  in_rate_reg  <= cfg_data;
                REG_OUTPUT_RATE: dst_rate_reg <= cfg_data;
                REG_CHANNELS:    chan_reg     <= cfg_data[1:0];
                REG_GAIN:        gain_reg     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            have_held_reg  <= 1'b0;
            rem_reg        <= 17'd0;
            skip_reg       <= 4'd0;
            n_reg          <= 4'd0;
            ch_reg         <= 1'b0;
            second_reg     <= 1'b0;
            cnt_reg        <= 4'd0;
            m_valid_reg    <= 1'b0;
            held_left_reg  <= 16'sd0;
            held_right_reg <= 16'sd0;
        end else begin
            state_reg      <= state_next;
            have_held_reg  <= have_held_next;
            rem_reg        <= rem_next;
            skip_reg       <= skip_next;
            n_reg          <= n_next;
            ch_reg         <= ch_next;
            second_reg     <= second_next;
            cnt_reg        <= cnt_next;
            m_valid_reg    <= m_valid_next;
            held_left_reg  <= held_left_next;
            held_right_reg <= held_right_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_left_reg  <= cur_left_next;
        cur_right_reg <= cur_right_next;
        end_reg       <= end_next;
        acc_reg       <= acc_next;
        rdiv_reg      <= rdiv_next;
        dvd_reg       <= dvd_next;
        neg_reg       <= neg_next;
        val_reg       <= val_next;
        res_left_reg  <= res_left_next;
        res_right_reg <= res_right_next;
        m_left_reg    <= m_left_next;
        m_right_reg   <= m_right_next;
        m_last_reg    <= m_last_next;
    end

    a_result_count: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= MAX_RESULTS)
        else $error("more results than allowed for one frame");

    a_skip_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(skip_reg) <= MAX_SKIP)
        else $error("frame skip count out of range");

    a_rem_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOP1 || state_reg == ST_LOOP2 || state_reg == ST_ADV_ADD)
        |-> (rem_reg < {1'b0, out_r}))
        else $error("phase remainder not below output rate");

    a_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_FIN) |-> (dvd_reg <= 16'd32768))
        else $error("interpolation quotient out of range");

    a_push_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH && slot_free) |=> (m_valid_reg && n_reg == $past(n_inc)))
        else $error("result transfer not loaded");

endmodule

`default_nettype wire

// ===== verif/linear_resampler_with_gain_top_tb.sv =====
`default_nettype none

module linear_resampler_with_gain_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lrg_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_FRAMES = 85;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic               last_of_run;
    } frame_out_t;

    class resampler_scoreboard;
        logic [15:0]        in_rate;
        logic [15:0]        dst_rate;
        logic [1:0]         chans;
        logic [15:0]        gain;
        logic signed [15:0] held_l;
        logic signed [15:0] held_r;
        bit                 have_held;
        int unsigned        phase_rem;
        int unsigned        skip_frames;
        frame_out_t         run_q[$];
        frame_out_t         resampled_q[$];
        int                 errors;

        function new();
            in_rate     = RESET_INPUT_RATE;
            dst_rate    = RESET_OUTPUT_RATE;
            chans       = RESET_CHANNELS;
            gain        = RESET_GAIN;
            held_l      = '0;
            held_r      = '0;
            have_held   = 1'b0;
            phase_rem   = 0;
            skip_frames = 0;
            errors      = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_INPUT_RATE:  in_rate  = val;
                REG_OUTPUT_RATE: dst_rate = val;
                REG_CHANNELS:    chans    = val[1:0];
                REG_GAIN:        gain     = val;
                default: ;
            endcase
        endfunction

        function int unsigned clamped(logic [15:0] rate);
            if (rate < RATE_MIN) return int'(RATE_MIN);
            if (rate > RATE_MAX) return int'(RATE_MAX);
            return int'(rate);
        endfunction

        function logic signed [15:0] sat16(longint v);
            if (v > 32767) return SAT_MAX;
            if (v < -32768) return SAT_MIN;
            return v[15:0];
        endfunction

        function logic signed [15:0] interp(logic signed [15:0] s0, logic signed [15:0] s1,
                                            int unsigned r, int unsigned o);
            longint acc;
            acc = longint'(s0) * (longint'(o) - longint'(r)) + longint'(s1) * longint'(r);
            return sat16(acc / longint'(o));
        endfunction

        function logic signed [15:0] apply_gain(logic signed [15:0] s);
            longint p;
            p = longint'(s) * longint'(gain);
            return sat16(p / (longint'(1) << GAIN_FRAC_BITS));
        endfunction

        function void advance_phase(int unsigned ir, int unsigned o);
            phase_rem += ir;
            while (phase_rem >= o) begin
                phase_rem -= o;
                skip_frames++;
            end
        endfunction

        function void queue_result(logic signed [15:0] a, logic signed [15:0] b, bit stereo);
            frame_out_t f;
            f.left_out    = apply_gain(a);
            f.right_out   = stereo ? apply_gain(b) : '0;
            f.last_of_run = 1'b0;
            run_q.push_back(f);
        endfunction

        function void resample_frame(logic signed [15:0] left_in, logic signed [15:0] right_in,
                                     logic blk_end);
            int unsigned        ir;
            int unsigned        o;
            bit                 stereo;
            logic signed [15:0] l;
            logic signed [15:0] r;
            ir     = clamped(in_rate);
            o      = clamped(dst_rate);
            stereo = (MAX_CHANNELS >= 2) && (chans >= 2);
            l      = left_in;
            r      = stereo ? right_in : '0;
            run_q.delete();
            if (phase_rem >= o) phase_rem = phase_rem % o;
            if (!have_held) begin
                skip_frames = 0;
                have_held   = 1'b1;
            end else begin
                while (skip_frames == 0 && run_q.size() < int'(MAX_RESULTS)) begin
                    queue_result(interp(held_l, l, phase_rem, o),
                                 interp(held_r, r, phase_rem, o), stereo);
                    advance_phase(ir, o);
                end
                if (skip_frames > 0) skip_frames--;
            end
            held_l = l;
            held_r = r;
            // block end: repeat the final frame, then restart the position
            if (blk_end) begin
                while (skip_frames == 0 && run_q.size() < int'(MAX_RESULTS)) begin
                    queue_result(held_l, held_r, stereo);
                    advance_phase(ir, o);
                end
                have_held   = 1'b0;
                phase_rem   = 0;
                skip_frames = 0;
            end
            skip_frames = skip_frames & 32'hF;
            if (run_q.size() > 0) run_q[run_q.size() - 1].last_of_run = 1'b1;
            foreach (run_q[i]) resampled_q.push_back(run_q[i]);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40) $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_frame(frame_out_t got);
            frame_out_t want;
            if (resampled_q.size() == 0) begin
                report($sformatf("result with nothing pending: left %0d right %0d last %0b",
                                 got.left_out, got.right_out, got.last_of_run));
                return;
            end
            want = resampled_q.pop_front();
            if (got.left_out !== want.left_out)
                report($sformatf("left_out %0d, expected %0d", got.left_out, want.left_out));
            if (got.right_out !== want.right_out)
                report($sformatf("right_out %0d, expected %0d", got.right_out, want.right_out));
            if (got.last_of_run !== want.last_of_run)
                report($sformatf("last_of_run %0b, expected %0b",
                                 got.last_of_run, want.last_of_run));
        endtask
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_left_sample;
    logic signed [15:0] s_right_sample;
    logic               s_block_end;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_left_out;
    logic signed [15:0] m_right_out;
    logic               m_last_of_run;

    resampler_scoreboard resampler = new();

    bit hold_req;
    int burst_left;
    int gap_max;

    linear_resampler_with_gain_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_left_sample  (s_left_sample),
        .s_right_sample (s_right_sample),
        .s_block_end    (s_block_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_out     (m_left_out),
        .m_right_out    (m_right_out),
        .m_last_of_run  (m_last_of_run)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin : result_monitor
        frame_out_t got;
        if (aresetn && m_valid && m_ready) begin
            got.left_out    = m_left_out;
            got.right_out   = m_right_out;
            got.last_of_run = m_last_of_run;
            resampler.check_frame(got);
        end
    end

    initial begin : receiver
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("linear_resampler_with_gain_top_tb: FAIL");
        $finish;
    end

    task write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        resampler.write_reg(idx, val);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task load_setting(logic [15:0] rate_in, logic [15:0] rate_out, logic [15:0] chan_word,
                      logic [15:0] gain_word);
        write_reg(REG_INPUT_RATE, rate_in);
        write_reg(REG_OUTPUT_RATE, rate_out);
        write_reg(REG_CHANNELS, chan_word);
        write_reg(REG_GAIN, gain_word);
    endtask

    task offer_frame(logic signed [15:0] l, logic signed [15:0] r, logic blk_end);
        int g;
        if (burst_left == 0) begin
            g = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (g > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_left_sample  <= l;
        s_right_sample <= r;
        s_block_end    <= blk_end;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        resampler.resample_frame(l, r, blk_end);
    endtask

    task wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (resampler.resampled_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2: return 16'($urandom_range(0, 8) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_rate();
        case ($urandom_range(0, 11))
            0: return 16'd8000;
            1: return 16'd48000;
            2: return 16'd44100;
            3: return 16'd11025;
            4: return 16'd22050;
            5: return 16'd32000;
            6: return 16'd0;
            7: return 16'hFFFF;
            8: return 16'($urandom);
            default: return 16'($urandom_range(8000, 48000));
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd4096;
            2: return 16'hFFFF;
            3: return 16'($urandom_range(2048, 8192));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_channels();
        return {14'($urandom), 2'($urandom_range(0, 3))};
    endfunction

    initial begin : stimulus
        int phase;
        int sent;
        int n;
        int block_left;
        logic blk_end;
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_left_sample  = '0;
        s_right_sample = '0;
        s_block_end    = 1'b0;
        hold_req       = 1'b0;
        burst_left     = 0;
        gap_max        = 3;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset setting: equal rates, mono, unity gain
        offer_frame(SAT_MAX, 16'sh1234, 1'b0);
        offer_frame(SAT_MIN, -16'sd77, 1'b0);
        offer_frame(16'sd0, SAT_MAX, 1'b0);
        offer_frame(-16'sd1, SAT_MIN, 1'b0);
        offer_frame(16'sd1, 16'sd5, 1'b1);
        wait_drained();

        // max upsampling, stereo, max gain; first block is a single frame
        load_setting(16'd8000, 16'd48000, 16'd2, 16'hFFFF);
        offer_frame(SAT_MAX, SAT_MIN, 1'b1);
        offer_frame(SAT_MIN, SAT_MAX, 1'b0);
        offer_frame(SAT_MAX, SAT_MIN, 1'b0);
        offer_frame(16'sd100, -16'sd100, 1'b1);
        wait_drained();

        // output rate lowered mid-block: remainder gets reduced
        load_setting(16'd44100, 16'd48000, 16'd1, 16'd4096);
        offer_frame(16'sd1000, 16'sd9, 1'b0);
        offer_frame(-16'sd1000, 16'sd9, 1'b0);
        wait_drained();
        write_reg(REG_OUTPUT_RATE, 16'd8000);
        write_reg(REG_CHANNELS, 16'hFFFF);
        offer_frame(SAT_MAX, 16'sd5, 1'b0);
        offer_frame(-16'sd7, SAT_MIN, 1'b1);
        wait_drained();

        // out-of-range rates clamp, channel code zero, zero gain
        load_setting(16'hFFFF, 16'h0000, 16'hFFFC, 16'd0);
        offer_frame(SAT_MAX, SAT_MAX, 1'b0);
        offer_frame(SAT_MIN, SAT_MIN, 1'b0);
        offer_frame(16'sd3, 16'sd4, 1'b0);
        offer_frame(-16'sd3, 16'sd4, 1'b0);
        offer_frame(SAT_MAX, 16'sd0, 1'b1);
        wait_drained();

        phase      = 0;
        sent       = 0;
        block_left = 0;
        while (sent < RANDOM_FRAMES) begin
            if (phase == 0) begin
                load_setting(pick_rate(), pick_rate(), pick_channels(), pick_gain());
            end else begin
                if ($urandom_range(0, 1)) write_reg(REG_INPUT_RATE, pick_rate());
                if ($urandom_range(0, 1)) write_reg(REG_OUTPUT_RATE, pick_rate());
                if ($urandom_range(0, 1)) write_reg(REG_CHANNELS, pick_channels());
                if ($urandom_range(0, 1)) write_reg(REG_GAIN, pick_gain());
            end
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            n = $urandom_range(8, 20);
            if (phase == 2) hold_req = 1'b1;
            for (int i = 0; i < n; i++) begin
                if (phase == 1 && i == n / 2) wait_drained();
                if (block_left == 0)
                    block_left = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24)
                                                             : $urandom_range(1, 10);
                blk_end = (block_left == 1);
                block_left--;
                offer_frame(pick_sample(), pick_sample(), blk_end);
                sent++;
            end
            wait_drained();
            phase++;
        end

        if (resampler.errors == 0 && resampler.resampled_q.size() == 0)
            $display("linear_resampler_with_gain_top_tb: PASS");
        else
            $display("linear_resampler_with_gain_top_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/lrg_pkg.sv
design/linear_resampler_with_gain_top.sv
verif/linear_resampler_with_gain_top_tb.sv
